@@ rtl/core/priority_task_table_scheduler_unit_defines.svh @@
// Assertion macros for the priority task table scheduler checks.
`ifndef PRIORITY_TASK_TABLE_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_TASK_TABLE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PTTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptts check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PTTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptts check failed");

`endif

@@ rtl/core/ptts_pkg.sv @@
// Types and constants shared by the priority task table scheduler files.
`timescale 1ns / 1ps
package ptts_pkg;

	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_RUN_NEXT = 2'd1;
	localparam logic [1:0] REQ_FINISH   = 2'd2;

	localparam logic [2:0] STATUS_PLACED  = 3'd0;
	localparam logic [2:0] STATUS_FULL    = 3'd1;
	localparam logic [2:0] STATUS_STARTED = 3'd2;
	localparam logic [2:0] STATUS_WRAPPED = 3'd3;
	localparam logic [2:0] STATUS_UPDATED = 3'd4;
	localparam logic [2:0] STATUS_NONE    = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  task_handle;
		logic [7:0]  task_priority;
		logic [31:0] elapsed_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic [7:0]  run_handle;
		logic [31:0] worst_ms;
		logic [63:0] sum_ms;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  handle;
		logic [7:0]  prio;
		logic [31:0] worst;
		logic [63:0] sum;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_RUN_RD,
		S_RUN_OUT,
		S_FIN_RD,
		S_FIN_WR
	} state_t;

endpackage

@@ rtl/core/ptts_table.sv @@
// Task entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ptts_table #(
	parameter int SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(SLOTS)-1:0]   wr_addr,
	input  ptts_pkg::entry_t           wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output ptts_pkg::entry_t           rd_data
);

	ptts_pkg::entry_t mem_q [SLOTS];
	ptts_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/priority_task_table_scheduler_unit.sv @@
// Priority task table scheduler: sorted task table with run and finish bookkeeping.
// Usage:
//  Raise start with a request on req; the request is taken at a rising edge where
//  start is high and busy is low. busy stays high while the request is worked on.
//  Each request with req_type 0, 1 or 2 gives one result on result, shown for one
//  cycle with done high; req_type 3 is taken and gives nothing.
// Sequencing (done is registered from the last state of each request):
//  register into a full table, run-next that wraps, finish with none outstanding:
//  answered from S_IDLE. Run-next that starts a task: S_RUN_RD, S_RUN_OUT.
//  Finish that updates statistics: S_FIN_RD, S_FIN_WR. Register: S_INS_RD and
//  S_INS_CMP per entry moved back, then the new entry is written. The entry memory
//  has one registered read port, so each entry moved costs a read and a compare.
//  A new request may be taken in the cycle in which done is shown.
// Reset (arst_n low) empties the table, clears the run pointer and the outstanding
//  task; the entry memory is not cleared, a fill count marks the valid entries.
// The receiver cannot stall: a result is dropped if not taken while done is high.
`timescale 1ns / 1ps
module priority_task_table_scheduler_unit #(
	parameter int SLOTS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ptts_pkg::req_t req,
	output logic           done,
	output ptts_pkg::rsp_t result
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	ptts_pkg::state_t state_q, state_d;
	ptts_pkg::req_t   req_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    run_ptr_q;
	logic [AW-1:0]    started_q;
	logic             pending_q;
	logic [AW-1:0]    idx_q;
	logic             done_q, done_d;
	ptts_pkg::rsp_t   result_q, result_d;

	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	ptts_pkg::entry_t wr_data, rd_data, new_entry;
	logic             accept, full, run_hit, shift_back;
	logic             place_en;
	logic [63:0]      sum_new;
	logic [31:0]      worst_new;

	ptts_table #(.SLOTS(SLOTS)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy       = (state_q != ptts_pkg::S_IDLE);
	assign accept     = start && !busy;
	assign full       = (fill_q == CW'(SLOTS));
	assign run_hit    = (run_ptr_q < fill_q);
	assign shift_back = (rd_data.prio > req_q.task_priority);
	assign sum_new    = rd_data.sum + 64'(req_q.elapsed_ms);
	assign worst_new  = (req_q.elapsed_ms > rd_data.worst) ? req_q.elapsed_ms : rd_data.worst;

	always_comb begin
		new_entry        = '0;
		new_entry.handle = req_q.task_handle;
		new_entry.prio   = req_q.task_priority;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptts_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						ptts_pkg::REQ_REGISTER: state_d = full ? ptts_pkg::S_IDLE : ptts_pkg::S_INS_RD;
						ptts_pkg::REQ_RUN_NEXT: state_d = run_hit ? ptts_pkg::S_RUN_RD : ptts_pkg::S_IDLE;
						ptts_pkg::REQ_FINISH:   state_d = pending_q ? ptts_pkg::S_FIN_RD : ptts_pkg::S_IDLE;
						default:                state_d = ptts_pkg::S_IDLE;
					endcase
				end
			end
			ptts_pkg::S_INS_RD:  state_d = (idx_q == '0) ? ptts_pkg::S_IDLE : ptts_pkg::S_INS_CMP;
			ptts_pkg::S_INS_CMP: state_d = shift_back ? ptts_pkg::S_INS_RD : ptts_pkg::S_IDLE;
			ptts_pkg::S_RUN_RD:  state_d = ptts_pkg::S_RUN_OUT;
			ptts_pkg::S_RUN_OUT: state_d = ptts_pkg::S_IDLE;
			ptts_pkg::S_FIN_RD:  state_d = ptts_pkg::S_FIN_WR;
			ptts_pkg::S_FIN_WR:  state_d = ptts_pkg::S_IDLE;
			default:             state_d = ptts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = new_entry;
		rd_en    = 1'b0;
		rd_addr  = idx_q - AW'(1);
		place_en = 1'b0;
		done_d   = 1'b0;
		result_d = '0;
		unique case (state_q)
			ptts_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						ptts_pkg::REQ_REGISTER: begin
							done_d          = full;
							result_d.status = ptts_pkg::STATUS_FULL;
						end
						ptts_pkg::REQ_RUN_NEXT: begin
							done_d          = !run_hit;
							result_d.status = ptts_pkg::STATUS_WRAPPED;
						end
						ptts_pkg::REQ_FINISH: begin
							done_d          = !pending_q;
							result_d.status = ptts_pkg::STATUS_NONE;
						end
						default: done_d = 1'b0;
					endcase
				end
			end
			ptts_pkg::S_INS_RD: begin
				if (idx_q == '0) begin
					wr_en    = 1'b1;
					place_en = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			ptts_pkg::S_INS_CMP: begin
				wr_en = 1'b1;
				if (shift_back) begin
					wr_data = rd_data;
				end else begin
					place_en = 1'b1;
				end
			end
			ptts_pkg::S_RUN_RD: begin
				rd_en   = 1'b1;
				rd_addr = started_q;
			end
			ptts_pkg::S_RUN_OUT: begin
				done_d              = 1'b1;
				result_d.status     = ptts_pkg::STATUS_STARTED;
				result_d.slot       = 3'(started_q);
				result_d.run_handle = rd_data.handle;
			end
			ptts_pkg::S_FIN_RD: begin
				rd_en   = 1'b1;
				rd_addr = started_q;
			end
			ptts_pkg::S_FIN_WR: begin
				wr_en            = 1'b1;
				wr_addr          = started_q;
				wr_data          = rd_data;
				wr_data.worst    = worst_new;
				wr_data.sum      = sum_new;
				done_d           = 1'b1;
				result_d.status  = ptts_pkg::STATUS_UPDATED;
				result_d.slot    = 3'(started_q);
				result_d.worst_ms = worst_new;
				result_d.sum_ms  = sum_new;
			end
			default: done_d = 1'b0;
		endcase
		if (place_en) begin
			done_d          = 1'b1;
			result_d.status = ptts_pkg::STATUS_PLACED;
			result_d.slot   = 3'(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ptts_pkg::S_IDLE;
			fill_q    <= '0;
			run_ptr_q <= '0;
			started_q <= '0;
			pending_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (accept && req.req_type == ptts_pkg::REQ_RUN_NEXT) begin
				if (run_hit) begin
					started_q <= run_ptr_q[AW-1:0];
					pending_q <= 1'b1;
					run_ptr_q <= run_ptr_q + CW'(1);
				end else begin
					run_ptr_q <= '0;
				end
			end
			if (place_en) begin
				fill_q <= fill_q + CW'(1);
				if (pending_q && started_q >= idx_q && started_q < AW'(SLOTS - 1)) begin
					started_q <= started_q + AW'(1);
				end
			end
			if (state_q == ptts_pkg::S_FIN_WR) begin
				pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			req_q <= req;
			idx_q <= fill_q[AW-1:0];
		end else if (state_q == ptts_pkg::S_INS_CMP && shift_back) begin
			idx_q <= idx_q - AW'(1);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/ptts_checker.sv @@
// Port-level checks for the priority task table scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "priority_task_table_scheduler_unit_defines.svh"
module ptts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input ptts_pkg::req_t req,
	input logic           done,
	input ptts_pkg::rsp_t result
);

	`PTTS_ASSERT_NOW(a_done_after_work, done, $past(busy) || $past(start))
	`PTTS_ASSERT_NOW(a_status_known, done, result.status <= ptts_pkg::STATUS_NONE)
	`PTTS_ASSERT_NOW(a_handle_only_started, done && result.status != ptts_pkg::STATUS_STARTED, result.run_handle == 8'd0)
	`PTTS_ASSERT_NOW(a_slot_zero_refused, done && (result.status == ptts_pkg::STATUS_FULL || result.status == ptts_pkg::STATUS_WRAPPED || result.status == ptts_pkg::STATUS_NONE), result.slot == 3'd0)
	`PTTS_ASSERT_NEXT(a_unknown_silent, start && !busy && req.req_type == 2'd3, !done && !busy)

endmodule

bind priority_task_table_scheduler_unit ptts_checker u_ptts_checker (.*);
